// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define B2DA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/b2da_pkg.sv =====
`default_nettype none

package b2da_pkg;

  localparam int unsigned IN_W       = 64;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned MAX_DIGITS = 20;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned REM_W      = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0]    ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0]   DIGIT_NINE = DIGIT_W'(9);
  localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(VALUE_BITS - 1);
  localparam logic [REM_W-1:0]     REM_FULL   = REM_W'(MAX_DIGITS);
  localparam logic [REM_W-1:0]     REM_ONE    = REM_W'(1);

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic advance;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/b2da_cell.sv =====
`default_nettype none

module b2da_cell import b2da_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       bit_i,
  input  wire digit_t     digit_i,
  output digit_t          digit_o,
  output logic            carry_o
);

  digit_t digit_q;
  digit_t digit_d;
  digit_t adj;

  always_comb begin
    adj     = (digit_q >= DIGIT_W'(5)) ? digit_q + DIGIT_W'(3) : digit_q;
    carry_o = adj[DIGIT_W-1];
    digit_d = digit_q;
    priority if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[DIGIT_W-2:0], bit_i};
    end else if (ctrl_i.advance) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

// ===== design/binary_to_decimal_ascii_core.sv =====
`default_nettype none

// Converts one unsigned number per request into its decimal text, one ASCII
// digit per output request, most significant first, leading zeros dropped
// (zero gives a single '0'); last_o marks the final digit. The number is
// shifted in bit by bit through a row of BCD digit cells (double dabble).
// The cells then shift up by one digit per cycle unless the output stalls:
// once for each suppressed leading zero, once to load the first digit and
// once for each digit sent. The next request is taken once the last digit
// of the current number has been taken. Only the MAX_DIGITS low decimal
// digits are kept.

`include "assert_macros.svh"

module binary_to_decimal_ascii_core import b2da_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [IN_W-1:0]   value_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CHAR_W-1:0]      digit_char_o,
  output logic                   last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  state_e                  state_q;
  logic [VALUE_BITS-1:0]   value_q;
  logic [BIT_CNT_W-1:0]    bit_cnt_q;
  logic [REM_W-1:0]        remain_q;
  logic                    out_valid_q;
  logic [CHAR_W-1:0]       char_q;
  logic                    last_q;

  cell_ctrl_t              ctrl;
  digit_t                  digits   [MAX_DIGITS];
  logic                    carries  [MAX_DIGITS];
  digit_t                  top_digit;
  logic                    in_acc;
  logic                    out_acc;
  logic                    load_out;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign out_acc   = out_valid_q && !out_stall_i;
  assign top_digit = digits[MAX_DIGITS-1];

  always_comb begin
    load_out = 1'b0;
    unique case (state_q)
      ST_SKIP: load_out = (top_digit != '0) || (remain_q == REM_ONE);
      ST_EMIT: load_out = out_acc && !last_q;
      default: load_out = 1'b0;
    endcase
    ctrl.clear   = in_acc;
    ctrl.dabble  = (state_q == ST_CONV);
    ctrl.advance = load_out || ((state_q == ST_SKIP) && !load_out);
  end

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic   bit_in;
    digit_t digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = value_q[VALUE_BITS-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carries[i-1];
      assign digit_in = digits[i-1];
    end
    b2da_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .digit_o (digits[i]),
      .carry_o (carries[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        remain_q    <= remain_q - REM_ONE;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            bit_cnt_q <= BIT_LAST;
            remain_q  <= REM_FULL;
            state_q   <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (bit_cnt_q == '0) begin
            state_q <= ST_SKIP;
          end else begin
            bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
          end
        end
        ST_SKIP: begin
          if (load_out) begin
            state_q <= ST_EMIT;
          end else begin
            remain_q <= remain_q - REM_ONE;
          end
        end
        ST_EMIT: begin
          if (out_acc && last_q) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      value_q <= value_i[VALUE_BITS-1:0];
    end else if (state_q == ST_CONV) begin
      value_q <= value_q << 1;
    end
    if (load_out) begin
      char_q <= ASCII_ZERO + CHAR_W'(top_digit);
      last_q <= (remain_q == REM_ONE);
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

  `B2DA_ASSERT_IMPL(a_valid_in_emit, clk_i, rst_ni, out_valid_o, state_q == ST_EMIT,
    "Result shown outside the emit phase.")
  `B2DA_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o,
    state_q == ST_CONV, "Accepted request did not start a conversion.")
  `B2DA_ASSERT_IMPL(a_last_ends, clk_i, rst_ni, out_valid_o && last_o, remain_q == '0,
    "Last digit flagged with digits still pending.")
  `B2DA_ASSERT_IMPL(a_char_range, clk_i, rst_ni, out_valid_o,
    (digit_char_o >= ASCII_ZERO) && (digit_char_o <= ASCII_ZERO + CHAR_W'(DIGIT_NINE)),
    "Output character is not a decimal digit.")

endmodule

`default_nettype wire
